### rtl/tcc_pkg.sv
// Shared types and constants for the touch coordinate conditioner.
// Used by every module of the block; depends on nothing.
package tcc_pkg;

    localparam int RAW_W = 12;
    localparam int AX_W = 8;
    localparam int AY_W = 9;
    localparam int SCR_W = 9;
    localparam int ORIENT_W = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    localparam int X_KNEE = 3000;
    localparam int X_OFS_LOW = 3900;
    localparam int X_OFS_HIGH = 3800;
    localparam int X_MAX = 239;
    localparam int Y_OFS = 360;
    localparam int Y_LIMIT = 320;
    localparam int Y_MAX = 319;
    localparam int DEADBAND = 4;

    // Reciprocals of 15 and 11 scaled by 2^17, rounded up.
    localparam int PROD_W = 26;
    localparam int RECIP_SHIFT = 17;
    localparam int X_RECIP = 8739;
    localparam int Y_RECIP = 11916;

    typedef enum logic [ORIENT_W-1:0] {
        ORIENT_PORTRAIT_ONE  = 2'd0,
        ORIENT_PORTRAIT_TWO  = 2'd1,
        ORIENT_LANDSCAPE_ONE = 2'd2,
        ORIENT_LANDSCAPE_TWO = 2'd3
    } orient_t;

    typedef struct packed {
        logic            touch;
        logic [AX_W-1:0] axis_x;
        logic [AY_W-1:0] axis_y;
    } sample_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [LEVEL_W-1:0] level;
    } q_status_t;

endpackage

### rtl/tcc_front.sv
// Front end: scales raw converter samples into axis values.
// Depends on tcc_pkg.
module tcc_front (
    input  logic                         touch_detected,
    input  logic [tcc_pkg::RAW_W-1:0]    raw_x,
    input  logic [tcc_pkg::RAW_W-1:0]    raw_y,
    output tcc_pkg::sample_t             sample
);

    logic [tcc_pkg::RAW_W-1:0]  x_diff;
    logic [tcc_pkg::PROD_W-1:0] x_prod;
    logic [tcc_pkg::AY_W-1:0]   x_quot;
    logic [tcc_pkg::RAW_W-1:0]  y_diff;
    logic [tcc_pkg::PROD_W-1:0] y_prod;
    logic [tcc_pkg::AY_W-1:0]   y_quot;

    always_comb
    begin
        if (raw_x <= tcc_pkg::RAW_W'(tcc_pkg::X_KNEE))
        begin
            x_diff = tcc_pkg::RAW_W'(tcc_pkg::X_OFS_LOW) - raw_x;
        end
        else if (raw_x <= tcc_pkg::RAW_W'(tcc_pkg::X_OFS_HIGH))
        begin
            x_diff = tcc_pkg::RAW_W'(tcc_pkg::X_OFS_HIGH) - raw_x;
        end
        else
        begin
            x_diff = '0;
        end
        x_prod = tcc_pkg::PROD_W'(x_diff) * tcc_pkg::PROD_W'(tcc_pkg::X_RECIP);
        x_quot = x_prod[tcc_pkg::RECIP_SHIFT +: tcc_pkg::AY_W];

        if (raw_y <= tcc_pkg::RAW_W'(tcc_pkg::Y_OFS))
        begin
            y_diff = '0;
        end
        else
        begin
            y_diff = raw_y - tcc_pkg::RAW_W'(tcc_pkg::Y_OFS);
        end
        y_prod = tcc_pkg::PROD_W'(y_diff) * tcc_pkg::PROD_W'(tcc_pkg::Y_RECIP);
        y_quot = y_prod[tcc_pkg::RECIP_SHIFT +: tcc_pkg::AY_W];

        sample.touch = touch_detected;
        if (x_quot > tcc_pkg::AY_W'(tcc_pkg::X_MAX))
        begin
            sample.axis_x = tcc_pkg::AX_W'(tcc_pkg::X_MAX);
        end
        else
        begin
            sample.axis_x = x_quot[tcc_pkg::AX_W-1:0];
        end
        if (y_quot >= tcc_pkg::AY_W'(tcc_pkg::Y_LIMIT))
        begin
            sample.axis_y = tcc_pkg::AY_W'(tcc_pkg::Y_MAX);
        end
        else
        begin
            sample.axis_y = y_quot;
        end
    end

endmodule

### rtl/tcc_queue.sv
// Two-entry queue of scaled samples between the front and back ends.
// Depends on tcc_pkg.
module tcc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tcc_pkg::sample_t     push_data,
    input  logic                 pop,
    output tcc_pkg::sample_t     head,
    output tcc_pkg::q_status_t   status
);

    tcc_pkg::sample_t                entries_reg [tcc_pkg::QUEUE_DEPTH];
    logic                            wr_ptr_reg;
    logic                            wr_ptr_next;
    logic                            rd_ptr_reg;
    logic                            rd_ptr_next;
    logic [tcc_pkg::LEVEL_W-1:0]     level_reg;
    logic [tcc_pkg::LEVEL_W-1:0]     level_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head = entries_reg[rd_ptr_reg];
    assign status.level = level_reg;
    assign status.full = (level_reg == tcc_pkg::LEVEL_W'(tcc_pkg::QUEUE_DEPTH));
    assign status.empty = (level_reg == '0);

endmodule

### rtl/tcc_back.sv
// Back end: deadband on held axes, orientation mapping, window test and result register.
// Depends on tcc_pkg.
module tcc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [tcc_pkg::ORIENT_W-1:0]  cfg_orientation,
    input  tcc_pkg::sample_t              head,
    input  tcc_pkg::q_status_t            q_status,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tcc_pkg::SCR_W-1:0]     screen_x,
    output logic [tcc_pkg::SCR_W-1:0]     screen_y,
    output logic                          is_pressed,
    output logic                          was_pressed
);

    tcc_pkg::orient_t               orient_reg;
    logic [tcc_pkg::AX_W-1:0]       held_x_reg;
    logic [tcc_pkg::AX_W-1:0]       held_x_next;
    logic [tcc_pkg::AY_W-1:0]       held_y_reg;
    logic [tcc_pkg::AY_W-1:0]       held_y_next;
    logic                           pressed_reg;
    logic                           pressed_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [tcc_pkg::SCR_W-1:0]      sx_reg;
    logic [tcc_pkg::SCR_W-1:0]      sx_next;
    logic [tcc_pkg::SCR_W-1:0]      sy_reg;
    logic [tcc_pkg::SCR_W-1:0]      sy_next;
    logic                           is_pressed_reg;
    logic                           was_pressed_reg;
    logic [tcc_pkg::AX_W-1:0]       dx;
    logic [tcc_pkg::AY_W-1:0]       dy;
    logic [tcc_pkg::SCR_W-1:0]      inv_x;
    logic [tcc_pkg::SCR_W-1:0]      inv_y;
    logic                           in_window;

    assign pop = !q_status.empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        dx = (head.axis_x > held_x_reg) ? head.axis_x - held_x_reg
                                        : held_x_reg - head.axis_x;
        dy = (head.axis_y > held_y_reg) ? head.axis_y - held_y_reg
                                        : held_y_reg - head.axis_y;
        held_x_next = held_x_reg;
        held_y_next = held_y_reg;
        if (head.touch && dx > tcc_pkg::AX_W'(tcc_pkg::DEADBAND))
        begin
            held_x_next = head.axis_x;
        end
        if (head.touch && dy > tcc_pkg::AY_W'(tcc_pkg::DEADBAND))
        begin
            held_y_next = head.axis_y;
        end

        inv_x = tcc_pkg::SCR_W'(tcc_pkg::X_MAX) - tcc_pkg::SCR_W'(held_x_next);
        inv_y = tcc_pkg::SCR_W'(tcc_pkg::Y_MAX) - held_y_next;
        case (orient_reg)
            tcc_pkg::ORIENT_PORTRAIT_ONE:
            begin
                sx_next = inv_x;
                sy_next = inv_y;
            end
            tcc_pkg::ORIENT_PORTRAIT_TWO:
            begin
                sx_next = tcc_pkg::SCR_W'(held_x_next);
                sy_next = held_y_next;
            end
            tcc_pkg::ORIENT_LANDSCAPE_ONE:
            begin
                sx_next = inv_y;
                sy_next = tcc_pkg::SCR_W'(held_x_next);
            end
            default:
            begin
                sx_next = held_y_next;
                sy_next = inv_x;
            end
        endcase

        if (orient_reg inside {tcc_pkg::ORIENT_PORTRAIT_ONE, tcc_pkg::ORIENT_PORTRAIT_TWO})
        begin
            in_window = (sx_next != '0) && (sx_next < tcc_pkg::SCR_W'(tcc_pkg::X_MAX))
                     && (sy_next != '0) && (sy_next < tcc_pkg::SCR_W'(tcc_pkg::Y_MAX));
        end
        else
        begin
            in_window = (sx_next != '0) && (sx_next < tcc_pkg::SCR_W'(tcc_pkg::Y_MAX))
                     && (sy_next != '0) && (sy_next < tcc_pkg::SCR_W'(tcc_pkg::X_MAX));
        end
        pressed_next = head.touch && in_window;

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg <= tcc_pkg::ORIENT_PORTRAIT_ONE;
            held_x_reg <= '0;
            held_y_reg <= '0;
            pressed_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                orient_reg <= tcc_pkg::orient_t'(cfg_orientation);
            end
            if (pop)
            begin
                held_x_reg <= held_x_next;
                held_y_reg <= held_y_next;
                pressed_reg <= pressed_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            is_pressed_reg <= pressed_next;
            was_pressed_reg <= pressed_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign screen_x = sx_reg;
    assign screen_y = sy_reg;
    assign is_pressed = is_pressed_reg;
    assign was_pressed = was_pressed_reg;

endmodule

### rtl/touch_coordinate_conditioner.sv
// Top level of the touch coordinate conditioner: front end, sample queue and back end.
// Depends on tcc_pkg, tcc_front, tcc_queue and tcc_back.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    touch_detected, raw_x, raw_y
// out      output     out_valid / out_stall  screen_x, screen_y, is_pressed, was_pressed
// cfg      input      cfg_valid / cfg_ready  cfg_orientation
//
// One request per cycle is sustained while out_stall stays low.
// out_valid rises once an accepted request has passed through the queue and been popped into the
// result register; a stalled output can hold the pop back.
// The back end's deadband update on the held axes forms the feedback loop through the held-axis registers.
// Reset clears the held axes, the pressed flag, the orientation and the queue.
// A stalled output fills the two-entry queue, after which in_stall rises.
module touch_coordinate_conditioner (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcc_pkg::ORIENT_W-1:0]  cfg_orientation,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          touch_detected,
    input  logic [tcc_pkg::RAW_W-1:0]     raw_x,
    input  logic [tcc_pkg::RAW_W-1:0]     raw_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tcc_pkg::SCR_W-1:0]     screen_x,
    output logic [tcc_pkg::SCR_W-1:0]     screen_y,
    output logic                          is_pressed,
    output logic                          was_pressed
);

    tcc_pkg::sample_t    front_sample;
    tcc_pkg::sample_t    q_head;
    tcc_pkg::q_status_t  q_status;
    logic                q_push;
    logic                q_pop;

    assign cfg_ready = 1'b1;
    assign in_stall = q_status.full;
    assign q_push = in_valid && !in_stall;

    tcc_front u_front (
        .touch_detected (touch_detected),
        .raw_x          (raw_x),
        .raw_y          (raw_y),
        .sample         (front_sample)
    );

    tcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_sample),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    tcc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid && cfg_ready),
        .cfg_orientation (cfg_orientation),
        .head            (q_head),
        .q_status        (q_status),
        .pop             (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .screen_x        (screen_x),
        .screen_y        (screen_y),
        .is_pressed      (is_pressed),
        .was_pressed     (was_pressed)
    );

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.level <= tcc_pkg::LEVEL_W'(tcc_pkg::QUEUE_DEPTH))
        else $error("Queue level exceeds its depth.");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("Queue popped while empty.");

    a_pressed_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_pressed |-> screen_x != '0 && screen_y != '0
            && screen_x < tcc_pkg::SCR_W'(tcc_pkg::Y_MAX)
            && screen_y < tcc_pkg::SCR_W'(tcc_pkg::Y_MAX))
        else $error("Pressed result lies outside the window.");

endmodule

### tb/testbench.sv
// Self-checking testbench for touch_coordinate_conditioner: drives touch samples and
// orientation writes, predicts every screen result and compares it in arrival order.
// Depends on tcc_pkg and the touch_coordinate_conditioner RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int X_DIV = 15;
    localparam int Y_DIV = 11;
    localparam int LONG_HOLD = 120;

    typedef struct packed {
        logic [tcc_pkg::SCR_W-1:0] screen_x;
        logic [tcc_pkg::SCR_W-1:0] screen_y;
        logic                      is_pressed;
        logic                      was_pressed;
    } touch_report_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [tcc_pkg::ORIENT_W-1:0] cfg_orientation;
    logic                         in_valid;
    logic                         in_stall;
    logic                         touch_detected;
    logic [tcc_pkg::RAW_W-1:0]    raw_x;
    logic [tcc_pkg::RAW_W-1:0]    raw_y;
    logic                         out_valid;
    logic                         out_stall;
    logic [tcc_pkg::SCR_W-1:0]    screen_x;
    logic [tcc_pkg::SCR_W-1:0]    screen_y;
    logic                         is_pressed;
    logic                         was_pressed;

    logic [tcc_pkg::AX_W-1:0] held_ax;
    logic [tcc_pkg::AY_W-1:0] held_ay;
    logic                     held_pressed;
    tcc_pkg::orient_t         orient_now;

    touch_report_t expected_reports[$];
    int            error_count;
    bit            src_idle_en;
    bit            sink_idle_en;
    bit            long_hold_req;

    touch_coordinate_conditioner dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_orientation (cfg_orientation),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .touch_detected  (touch_detected),
        .raw_x           (raw_x),
        .raw_y           (raw_y),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .screen_x        (screen_x),
        .screen_y        (screen_y),
        .is_pressed      (is_pressed),
        .was_pressed     (was_pressed)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [tcc_pkg::AX_W-1:0] x_axis_of(logic [tcc_pkg::RAW_W-1:0] raw);
        int v;
        v = (int'(raw) <= tcc_pkg::X_KNEE) ? tcc_pkg::X_OFS_LOW - int'(raw)
                                            : tcc_pkg::X_OFS_HIGH - int'(raw);
        v = v / X_DIV;
        if (v > tcc_pkg::X_MAX)
            v = tcc_pkg::X_MAX;
        else if (v < 0)
            v = 0;
        return v[tcc_pkg::AX_W-1:0];
    endfunction

    function automatic logic [tcc_pkg::AY_W-1:0] y_axis_of(logic [tcc_pkg::RAW_W-1:0] raw);
        int v;
        v = (int'(raw) - tcc_pkg::Y_OFS) / Y_DIV;
        if (v <= 0)
            v = 0;
        else if (v >= tcc_pkg::Y_LIMIT)
            v = tcc_pkg::Y_MAX;
        return v[tcc_pkg::AY_W-1:0];
    endfunction

    function automatic int deadband_hold(int fresh, int held);
        int d;
        d = (fresh > held) ? fresh - held : held - fresh;
        return (d > tcc_pkg::DEADBAND) ? fresh : held;
    endfunction

    task automatic predict_report(logic touch, logic [tcc_pkg::RAW_W-1:0] rx,
                                  logic [tcc_pkg::RAW_W-1:0] ry);
        touch_report_t r;
        int            sx;
        int            sy;
        bit            in_win;
        r.was_pressed = held_pressed;
        if (touch)
        begin
            held_ax = tcc_pkg::AX_W'(deadband_hold(int'(x_axis_of(rx)), int'(held_ax)));
            held_ay = tcc_pkg::AY_W'(deadband_hold(int'(y_axis_of(ry)), int'(held_ay)));
        end
        case (orient_now)
            tcc_pkg::ORIENT_PORTRAIT_ONE:
            begin
                sx = tcc_pkg::X_MAX - int'(held_ax);
                sy = tcc_pkg::Y_MAX - int'(held_ay);
            end
            tcc_pkg::ORIENT_PORTRAIT_TWO:
            begin
                sx = int'(held_ax);
                sy = int'(held_ay);
            end
            tcc_pkg::ORIENT_LANDSCAPE_ONE:
            begin
                sx = tcc_pkg::Y_MAX - int'(held_ay);
                sy = int'(held_ax);
            end
            default:
            begin
                sx = int'(held_ay);
                sy = tcc_pkg::X_MAX - int'(held_ax);
            end
        endcase
        if (orient_now == tcc_pkg::ORIENT_PORTRAIT_ONE
            || orient_now == tcc_pkg::ORIENT_PORTRAIT_TWO)
            in_win = sx > 0 && sx < tcc_pkg::X_MAX && sy > 0 && sy < tcc_pkg::Y_MAX;
        else
            in_win = sx > 0 && sx < tcc_pkg::Y_MAX && sy > 0 && sy < tcc_pkg::X_MAX;
        held_pressed = touch && in_win;
        r.screen_x = sx[tcc_pkg::SCR_W-1:0];
        r.screen_y = sy[tcc_pkg::SCR_W-1:0];
        r.is_pressed = held_pressed;
        expected_reports.push_back(r);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        touch_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
                report_mismatch("result with no request pending", 1, 0);
            else
            begin
                want = expected_reports.pop_front();
                if (screen_x !== want.screen_x)
                    report_mismatch("screen_x", screen_x, want.screen_x);
                if (screen_y !== want.screen_y)
                    report_mismatch("screen_y", screen_y, want.screen_y);
                if (is_pressed !== want.is_pressed)
                    report_mismatch("is_pressed", is_pressed, want.is_pressed);
                if (was_pressed !== want.was_pressed)
                    report_mismatch("was_pressed", was_pressed, want.was_pressed);
            end
        end
    end

    initial
    begin
        int n;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    task automatic send_sample(logic touch, logic [tcc_pkg::RAW_W-1:0] rx,
                               logic [tcc_pkg::RAW_W-1:0] ry);
        int n;
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        touch_detected <= touch;
        raw_x <= rx;
        raw_y <= ry;
        do @(posedge clk); while (in_stall);
        predict_report(touch, rx, ry);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_orientation(tcc_pkg::orient_t value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_orientation <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        orient_now = value;
    endtask

    task automatic test_reset_release();
        send_sample(1'b0, 12'hFFF, 12'hFFF);
        send_sample(1'b0, 12'h000, 12'h000);
    endtask

    task automatic test_axis_extremes();
        send_sample(1'b1, 12'd0, 12'd0);
        send_sample(1'b1, 12'd3000, 12'd360);
        send_sample(1'b1, 12'd3001, 12'd371);
        send_sample(1'b1, 12'd4095, 12'd3879);
        send_sample(1'b1, 12'd2400, 12'd3880);
        send_sample(1'b1, 12'd1, 12'd4095);
        send_sample(1'b1, 12'd3800, 12'd1000);
        send_sample(1'b0, 12'd2000, 12'd2000);
    endtask

    task automatic test_deadband();
        send_sample(1'b1, 12'd2400, 12'd1460);
        send_sample(1'b1, 12'd2340, 12'd1504);
        send_sample(1'b1, 12'd2325, 12'd1515);
        send_sample(1'b1, 12'd2415, 12'd1449);
        send_sample(1'b0, 12'd0, 12'd4095);
        send_sample(1'b1, 12'd2400, 12'd1460);
    endtask

    task automatic test_orientations();
        tcc_pkg::orient_t o;
        for (int i = 1; i <= 4; i++)
        begin
            o = tcc_pkg::orient_t'(i % 4);
            write_orientation(o);
            send_sample(1'b1, 12'd1500, 12'd2000);
            send_sample(1'b0, 12'd1500, 12'd2000);
        end
    endtask

    task automatic test_backpressure();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        wait_drained();
        long_hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_sample(1'b1, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        wait_drained();
    endtask

    task automatic test_random_traffic(int count, bit with_idle);
        int  cx;
        int  cy;
        bit  touch;
        int  edges[8] = '{0, 360, 371, 3000, 3001, 3879, 3880, 4095};
        cx = 2000;
        cy = 2000;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
            begin
                src_idle_en = with_idle && $urandom_range(0, 2) != 0;
                sink_idle_en = with_idle && $urandom_range(0, 2) != 0;
            end
            if (with_idle && i % 250 == 249)
                write_orientation(tcc_pkg::orient_t'($urandom_range(0, 3)));
            touch = $urandom_range(0, 9) != 0;
            case ($urandom_range(0, 3))
                0:
                begin
                    cx = $urandom_range(0, 4095);
                    cy = $urandom_range(0, 4095);
                end
                3:
                begin
                    cx = edges[$urandom_range(0, 7)];
                    cy = edges[$urandom_range(0, 7)];
                end
                default:
                begin
                    cx = cx + $urandom_range(0, 160) - 80;
                    cy = cy + $urandom_range(0, 120) - 60;
                end
            endcase
            cx = (cx < 0) ? 0 : (cx > 4095) ? 4095 : cx;
            cy = (cy < 0) ? 0 : (cy > 4095) ? 4095 : cy;
            send_sample(touch, cx[tcc_pkg::RAW_W-1:0], cy[tcc_pkg::RAW_W-1:0]);
        end
    endtask

    initial
    begin
        error_count = 0;
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        long_hold_req = 1'b0;
        held_ax = '0;
        held_ay = '0;
        held_pressed = 1'b0;
        orient_now = tcc_pkg::ORIENT_PORTRAIT_ONE;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_orientation <= tcc_pkg::ORIENT_PORTRAIT_ONE;
        in_valid <= 1'b0;
        touch_detected <= 1'b0;
        raw_x <= '0;
        raw_y <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_release();
        test_axis_extremes();
        test_deadband();
        test_orientations();
        test_backpressure();
        test_random_traffic(1000, 1'b1);
        write_orientation(tcc_pkg::ORIENT_LANDSCAPE_TWO);
        test_random_traffic(200, 1'b0);

        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
